// ===== hw/rtl/joystick_axis_dejitter_calibrate_top_macros.svh =====
// Assertion macros shared by the joystick axis conditioner.
`ifndef JOYSTICK_AXIS_DEJITTER_CALIBRATE_TOP_MACROS_SVH
`define JOYSTICK_AXIS_DEJITTER_CALIBRATE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JADC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JADC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/jadc_pkg.sv =====
// Types and constants of the joystick axis conditioner.
package jadc_pkg;

    localparam logic [15:0] AXIS_MIN    = 16'd0;
    localparam logic [15:0] AXIS_CENTER = 16'd32768;
    localparam logic [15:0] AXIS_MAX    = 16'd65535;

    localparam logic [15:0] SPAN_LEFT  = AXIS_CENTER - AXIS_MIN;
    localparam logic [15:0] SPAN_RIGHT = AXIS_MAX - AXIS_CENTER;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_JITTER_ENABLE = 3'd0,
        CFG_JITTER_MARGIN = 3'd1,
        CFG_JITTER_HOLD   = 3'd2,
        CFG_CAL_ENABLE    = 3'd3,
        CFG_LEFT_LIMIT    = 3'd4,
        CFG_RIGHT_LIMIT   = 3'd5,
        CFG_NULL_WIDTH    = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic        jitter_enable;
        logic [15:0] jitter_margin;
        logic [7:0]  jitter_hold;
        logic        cal_enable;
        logic [15:0] left_limit;
        logic [15:0] right_limit;
        logic [15:0] null_width;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_JIT,
        ST_BOUND,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/jadc_if.sv =====
// Handshake interfaces for sample words, value words and register writes.
interface jadc_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface jadc_value_if;
    logic        valid;
    logic        ready;
    logic [15:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface jadc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/jadc_cfg_regs.sv =====
// Configuration register file of the joystick axis conditioner.
module jadc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    jadc_cfg_if.sink      cfg,
    output jadc_pkg::cfg_t cfg_q
);
    import jadc_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.jitter_enable <= 1'b0;
            regs_reg.jitter_margin <= 16'd0;
            regs_reg.jitter_hold   <= 8'd0;
            regs_reg.cal_enable    <= 1'b0;
            regs_reg.left_limit    <= 16'd0;
            regs_reg.right_limit   <= 16'hFFFF;
            regs_reg.null_width    <= 16'd0;
        end
        else if (cfg.valid)
        begin
            // Indexes past the end of the list are dropped.
            unique case (cfg_index_t'(cfg.index))
                CFG_JITTER_ENABLE: regs_reg.jitter_enable <= cfg.data[0];
                CFG_JITTER_MARGIN: regs_reg.jitter_margin <= cfg.data;
                CFG_JITTER_HOLD:   regs_reg.jitter_hold   <= cfg.data[7:0];
                CFG_CAL_ENABLE:    regs_reg.cal_enable    <= cfg.data[0];
                CFG_LEFT_LIMIT:    regs_reg.left_limit    <= cfg.data;
                CFG_RIGHT_LIMIT:   regs_reg.right_limit   <= cfg.data;
                CFG_NULL_WIDTH:    regs_reg.null_width    <= cfg.data;
                default:           regs_reg <= regs_reg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/jadc_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module jadc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  jadc_pkg::div_req_t req,
    output jadc_pkg::div_rsp_t rsp
);
    import jadc_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [15:0]          rem_reg, rem_next;
    logic [15:0]          low_reg, low_next;
    logic [15:0]          divisor_reg, divisor_next;
    logic [16:0]          rem_shift;
    logic                 fits;

    // The caller guarantees the dividend is below divisor * 2^16, so the
    // upper half starts below the divisor and the quotient fits in 16 bits.
    assign rem_shift = {rem_reg, low_reg[15]};
    assign fits      = rem_shift >= {1'b0, divisor_reg};

    always_comb
    begin
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        rem_next     = rem_reg;
        low_next     = low_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            cnt_next     = DIV_CNT_W'(DIV_STEPS);
            rem_next     = req.dividend[31:16];
            low_next     = req.dividend[15:0];
            divisor_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            done_next = (cnt_reg == DIV_CNT_W'(1));
            rem_next  = fits ? 16'(rem_shift - {1'b0, divisor_reg}) : rem_shift[15:0];
            low_next  = {low_reg[14:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        low_reg     <= low_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy     = (cnt_reg != '0);
    assign rsp.done     = done_reg;
    assign rsp.quotient = low_reg;

endmodule

// ===== hw/rtl/joystick_axis_dejitter_calibrate_top.sv =====
// Top level of the joystick axis conditioner: sequencer, datapath and output register.
//
// Usage. Raw axis readings arrive as words on the samples channel and one
// conditioned word per reading leaves on the values channel; both use a
// valid/ready handshake. Registers are written through the cfg channel, which
// is always ready; write it only while no reading is in flight.
// Sequence. An accepted reading walks through the jitter step, the bound
// step and the setup step, then the multiply step, the wait on the serial
// divider and the hand-over step when the rescaling path is taken.
// Readings inside the null zone, on a full-width side, on an empty side or
// with calibration off skip the divider. The sequencer takes one reading at
// a time and returns to the idle state before it takes the next word.
// Samples ready is high only while the sequencer is idle.
// Stalls. The finished value sits in an output register, so a new reading is
// taken while the previous value waits; a second finished value then waits
// in the hand-over state until the output register frees up.
// Reset. All registers take their documented values, the held position and
// repeat count clear to zero and the output channel goes empty.
module joystick_axis_dejitter_calibrate_top (
    input  logic          clk,
    input  logic          rst_n,
    jadc_sample_if.sink   samples,
    jadc_value_if.source  values,
    jadc_cfg_if.sink      cfg
);
    import jadc_pkg::*;

    cfg_t     cfg_q;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t state_reg, state_next;

    logic [15:0] sample_reg, sample_next;
    logic [15:0] held_reg, held_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] res_reg, res_next;
    logic        dead_reg, dead_next;
    logic [15:0] xc_reg, xc_next;
    logic [15:0] nlo_reg, nlo_next;
    logic [15:0] nhi_reg, nhi_next;
    logic [15:0] base_reg, base_next;
    logic [15:0] span_reg, span_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] off_reg, off_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_value_reg, out_value_next;

    logic [15:0]        win_lo;
    logic [16:0]        win_hi_wide;
    logic [15:0]        win_hi;
    logic               outside;
    logic [16:0]        nlo_wide;
    logic [16:0]        nhi_wide;
    logic [15:0]        x_lo;
    logic signed [17:0] w_side;
    logic signed [17:0] off_side;
    logic               side_left;
    logic               passthru;
    logic               empty_side;
    logic [15:0]        off_capped;
    logic               out_load;

    jadc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    jadc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Window round the held position, saturating at both ends of the scale.
    assign win_lo      = (held_reg >= cfg_q.jitter_margin) ? held_reg - cfg_q.jitter_margin
                                                            : 16'd0;
    assign win_hi_wide = {1'b0, held_reg} + {1'b0, cfg_q.jitter_margin};
    assign win_hi      = win_hi_wide[16] ? 16'hFFFF : win_hi_wide[15:0];
    assign outside     = (sample_reg < win_lo) || (sample_reg > win_hi);

    // Null zone edges, again saturating at the ends of the scale.
    assign nlo_wide = {1'b0, AXIS_CENTER} - {1'b0, cfg_q.null_width};
    assign nhi_wide = {1'b0, AXIS_CENTER} + {1'b0, cfg_q.null_width};

    // The clamp to the left limit comes first, so crossed limits give the
    // right limit.
    assign x_lo = (res_reg < cfg_q.left_limit) ? cfg_q.left_limit : res_reg;

    // Width and offset of the side the clamped reading falls on.
    assign side_left = (xc_reg < AXIS_CENTER);
    assign w_side    = side_left
                     ? $signed({2'b00, nlo_reg}) - $signed({2'b00, cfg_q.left_limit})
                     : $signed({2'b00, cfg_q.right_limit}) - $signed({2'b00, nhi_reg});
    assign off_side  = side_left
                     ? $signed({2'b00, xc_reg}) - $signed({2'b00, cfg_q.left_limit})
                     : $signed({2'b00, xc_reg}) - $signed({2'b00, nhi_reg});
    assign passthru   = side_left ? (w_side == $signed({2'b00, SPAN_LEFT}))
                                  : (w_side == $signed({2'b00, SPAN_RIGHT}));
    assign empty_side = w_side[17] || (w_side == 18'sd0);
    // A negative offset counts as zero; one beyond the width is capped at it.
    assign off_capped = off_side[17]        ? 16'd0
                      : (off_side > w_side) ? w_side[15:0]
                      :                       off_side[15:0];

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || values.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        held_next      = held_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        dead_next      = dead_reg;
        xc_next        = xc_reg;
        nlo_next       = nlo_reg;
        nhi_next       = nhi_reg;
        base_next      = base_reg;
        span_next      = span_reg;
        width_next     = width_reg;
        off_next       = off_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {16'd0, off_reg} * {16'd0, span_reg};
        div_req.divisor  = width_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    sample_next = samples.sample;
                    state_next  = ST_JIT;
                end
            end
            ST_JIT:
            begin
                res_next = sample_reg;
                if (cfg_q.jitter_enable)
                begin
                    priority if (outside)
                    begin
                        count_next = 8'd0;
                        held_next  = sample_reg;
                    end
                    else if (count_reg < cfg_q.jitter_hold)
                    begin
                        count_next = count_reg + 8'd1;
                        res_next   = held_reg;
                    end
                    else
                    begin
                        count_next = 8'd0;
                        held_next  = sample_reg;
                    end
                end
                state_next = cfg_q.cal_enable ? ST_BOUND : ST_DONE;
            end
            ST_BOUND:
            begin
                nlo_next  = nlo_wide[16] ? 16'd0 : nlo_wide[15:0];
                nhi_next  = nhi_wide[16] ? 16'hFFFF : nhi_wide[15:0];
                dead_next = (res_reg >= nlo_next) && (res_reg <= nhi_next);
                xc_next   = (x_lo > cfg_q.right_limit) ? cfg_q.right_limit : x_lo;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                base_next  = side_left ? AXIS_MIN : AXIS_CENTER;
                span_next  = side_left ? SPAN_LEFT : SPAN_RIGHT;
                width_next = w_side[15:0];
                off_next   = off_capped;
                priority if (dead_reg)
                begin
                    res_next   = AXIS_CENTER;
                    state_next = ST_DONE;
                end
                else if (passthru)
                begin
                    res_next   = xc_reg;
                    state_next = ST_DONE;
                end
                else if (empty_side)
                begin
                    res_next   = base_next;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // The product is captured by the divider as it starts.
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next   = 16'({1'b0, base_reg} + {1'b0, div_rsp.quotient});
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (values.ready ? 1'b0 : out_valid_reg);
        out_value_next = out_load ? res_reg : out_value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 16'd0;
            count_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        res_reg       <= res_next;
        dead_reg      <= dead_next;
        xc_reg        <= xc_next;
        nlo_reg       <= nlo_next;
        nhi_reg       <= nhi_next;
        base_reg      <= base_next;
        span_reg      <= span_next;
        width_reg     <= width_next;
        off_reg       <= off_next;
        out_value_reg <= out_value_next;
    end

    assign samples.ready = (state_reg == ST_IDLE);
    assign values.valid  = out_valid_reg;
    assign values.value  = out_value_reg;

`include "joystick_axis_dejitter_calibrate_top_macros.svh"

    `JADC_ASSERT_NEXT(a_accept_starts, samples.valid && samples.ready, state_reg == ST_JIT, "accepted word did not start the jitter step")
    `JADC_ASSERT_SAME(a_div_in_state, div_rsp.busy || div_rsp.done, state_reg == ST_DIV, "divider active outside the divide state")
    `JADC_ASSERT_NEXT(a_hold_when_off, state_reg == ST_JIT && !cfg_q.jitter_enable, $stable(held_reg) && $stable(count_reg), "jitter state moved while the stage is off")
    `JADC_ASSERT_SAME(a_out_from_done, $rose(out_valid_reg), $past(state_reg) == ST_DONE, "output word loaded outside the hand-over state")

endmodule
